// ===== sv/pcot_pkg.sv =====
// Shared types and constants for the pin ownership conflict table.
package pcot_pkg;

  // Default table depth
  localparam int unsigned TableEntriesDef = 64;

  // Field widths
  localparam int unsigned PinW      = 6;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned ConflictW = 16;
  localparam int unsigned EntriesW  = 7;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    StatusOk       = 2'd0,
    StatusConflict = 2'd1,
    StatusFull     = 2'd2,
    StatusNotFound = 2'd3
  } status_e;

  // Operation codes
  typedef enum logic {
    OpClaim   = 1'b0,
    OpRelease = 1'b1
  } op_e;

  // One table slot
  typedef struct packed {
    logic            live;
    logic            shared;
    logic [PinW-1:0] pin;
  } entry_t;

  // Controller states
  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDone
  } state_e;

endpackage

// ===== sv/pcot_mem.sv =====
// Single-port-read, single-port-write slot memory with registered read data.
module pcot_mem #(
  parameter int unsigned Depth = pcot_pkg::TableEntriesDef,
  parameter int unsigned AddrW = 6
) (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [AddrW-1:0]     rd_addr_i,
  output pcot_pkg::entry_t     rd_data_o,
  input  logic                 wr_en_i,
  input  logic [AddrW-1:0]     wr_addr_i,
  input  pcot_pkg::entry_t     wr_data_i
);
  import pcot_pkg::*;

  entry_t mem_q [Depth];
  entry_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/pin_ownership_conflict_table_unit.sv =====
// Pin ownership conflict table: search sequencer, counters and result word.
// A scan starts when start is accepted; a hit ends the scan early, and an empty table skips it.
// The scan reads one slot per cycle from the slot memory; the StDone state then commits the result.
// A new request is taken only when idle, after the last is done; busy is low again in the strobe cycle.
// Reset clears the sequencer, slot count and conflict total; slot contents are not cleared.
// The receiver cannot stall: done_o is high for a single cycle; the result word holds until the next commit.
module pin_ownership_conflict_table_unit #(
  parameter int unsigned TABLE_ENTRIES = pcot_pkg::TableEntriesDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             opcode_i,
  input  logic [pcot_pkg::PinW-1:0]        pin_i,
  input  logic                             shared_request_i,
  output logic                             done_o,
  output logic [pcot_pkg::StatusW-1:0]     status_o,
  output logic [pcot_pkg::ConflictW-1:0]   conflicts_seen_o,
  output logic                             validation_failed_o,
  output logic [pcot_pkg::EntriesW-1:0]    entries_in_table_o
);
  import pcot_pkg::*;

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] CntFull = CW'(TABLE_ENTRIES);

  state_e              state_q, state_d;
  op_e                 op_q;
  logic [PinW-1:0]     pin_q;
  logic                shr_q;
  logic [CW-1:0]       idx_q;
  logic                hit_q;
  logic [AW-1:0]       hit_idx_q;
  logic                hit_shr_q;
  logic [CW-1:0]       cnt_q;
  logic [ConflictW-1:0] conf_q;
  status_e             status_q, status_d;
  logic                done_q;

  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  entry_t              rd_data;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  entry_t              wr_data;
  logic                conf_inc;
  logic                append;

  logic [CW-1:0]       next_idx;
  logic                match;
  logic                last;
  logic [31:0]         cnt_ext;

  pcot_mem #(
    .Depth (TABLE_ENTRIES),
    .AddrW (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // slot compare on the word just read
  assign next_idx = idx_q + 1'b1;
  assign match    = rd_data.live && (rd_data.pin == pin_q);
  assign last     = (next_idx == cnt_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          state_d = (cnt_q == '0) ? StDone : StScan;
        end
      end
      StScan: begin
        if (match || last) begin
          state_d = StDone;
        end
      end
      StDone: begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // memory access and commit decision
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = hit_idx_q;
    wr_data  = '{live: 1'b0, shared: hit_shr_q, pin: pin_q};
    conf_inc = 1'b0;
    append   = 1'b0;
    status_d = StatusOk;
    unique case (state_q)
      StIdle: begin
        rd_en = start;
      end
      StScan: begin
        rd_en   = !match && !last;
        rd_addr = next_idx[AW-1:0];
      end
      StDone: begin
        if (op_q == OpClaim) begin
          if (hit_q) begin
            if (!(hit_shr_q && shr_q)) begin
              conf_inc = 1'b1;
              status_d = StatusConflict;
            end
          end else if (cnt_q == CntFull) begin
            status_d = StatusFull;
          end else begin
            append  = 1'b1;
            wr_en   = 1'b1;
            wr_addr = cnt_q[AW-1:0];
            wr_data = '{live: 1'b1, shared: shr_q, pin: pin_q};
          end
        end else begin
          if (hit_q) begin
            // kill the matched slot, it is never reused
            wr_en = 1'b1;
          end else begin
            status_d = StatusNotFound;
          end
        end
      end
      default: ;
    endcase
  end

  // control and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      conf_q   <= '0;
      done_q   <= 1'b0;
      hit_q    <= 1'b0;
      idx_q    <= '0;
      status_q <= StatusOk;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == StDone);
      if (state_q == StIdle && start) begin
        hit_q <= 1'b0;
        idx_q <= '0;
      end
      if (state_q == StScan) begin
        if (match) begin
          hit_q <= 1'b1;
        end else if (!last) begin
          idx_q <= next_idx;
        end
      end
      if (state_q == StDone) begin
        status_q <= status_d;
        if (append) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (conf_inc && (conf_q != '1)) begin
          conf_q <= conf_q + 1'b1;
        end
      end
    end
  end

  // request word and match details
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start) begin
      op_q  <= op_e'(opcode_i);
      pin_q <= pin_i;
      shr_q <= shared_request_i;
    end
    if (state_q == StScan && match) begin
      hit_idx_q <= idx_q[AW-1:0];
      hit_shr_q <= rd_data.shared;
    end
  end

  // result word; counters change only at the commit edge
  assign cnt_ext             = 32'(cnt_q);
  assign busy                = (state_q != StIdle);
  assign done_o              = done_q;
  assign status_o            = status_q;
  assign conflicts_seen_o    = conf_q;
  assign validation_failed_o = (conf_q != '0);
  assign entries_in_table_o  = cnt_ext[EntriesW-1:0];

endmodule
